// ===== hdl/adler_pkg.sv =====
// Shared widths, constants and the lane-to-accumulator word type for the Adler-32 block.
package adler_pkg;

  localparam int LANES    = 4;
  // Lanes in use: a data word carries at most four bytes
  localparam int LANE_CNT = (LANES < 4) ? LANES : 4;

  localparam int COUNT_W  = 3;
  localparam int BSUM_W   = 10;   // up to four bytes summed
  localparam int WSUM_W   = 12;   // bytes weighted by up to four, summed
  localparam int NL_W     = 18;   // low sum times up to four
  localparam int HSUM_W   = 19;   // high + n*low + weighted sum

  localparam logic [COUNT_W-1:0] LANE_CNT_C = COUNT_W'(LANE_CNT);
  localparam logic [16:0]        ADLER_MOD  = 17'd65521;
  localparam logic [31:0]        START_RST  = 32'd1;
  localparam logic [4:0]         FOLD_MUL   = 5'd15;   // 2^16 mod 65521

  typedef struct packed {
    logic [BSUM_W-1:0]  byte_sum;
    logic [WSUM_W-1:0]  weighted_sum;
    logic [COUNT_W-1:0] count;
    logic               restart;
  } lane_sum_t;

endpackage

// ===== hdl/adler32_checksum.sv =====
// Adler-32 running checksum: four byte lanes, a merge register, then the sum accumulator.
// An accepted word is held in the merge register, then in the accumulator's sums.
// Throughput: one word per cycle unless m_tready stalls; the low/high update loop in the
// accumulator sets this, with the lanes' byte and weighted sums registered ahead of it.
// Reset: low sum 1, high sum 0, start value 1, both pipeline stages emptied.
module adler32_checksum (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,      // start_value: high sum [31:16], low sum [15:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,          // data_word [31:0], byte_count [34:32], zeros [39:35]
  input  logic        s_tuser,          // restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata           // checksum: low sum [15:0], high sum [31:16]
);

  logic [31:0] start_value;
  logic [adler_pkg::COUNT_W-1:0] count_in, count_sat;
  logic [7:0]  lane_byte     [adler_pkg::LANE_CNT];
  logic [10:0] lane_weighted [adler_pkg::LANE_CNT];
  logic [adler_pkg::BSUM_W-1:0] byte_sum;
  logic [adler_pkg::WSUM_W-1:0] weighted_sum;
  adler_pkg::lane_sum_t merged, stage;
  logic stage_valid;
  logic acc_ready;

  assign count_in  = s_tdata[34:32];
  assign count_sat = (count_in > adler_pkg::LANE_CNT_C) ? adler_pkg::LANE_CNT_C : count_in;

  for (genvar g = 0; g < adler_pkg::LANE_CNT; g++) begin : g_lane
    adler_lane u_lane (
      .data_word     (s_tdata[31:0]),
      .count         (count_sat),
      .lane_idx      (adler_pkg::COUNT_W'(g)),
      .lane_byte     (lane_byte[g]),
      .lane_weighted (lane_weighted[g])
    );
  end

  // merge the lanes
  always_comb begin
    byte_sum     = '0;
    weighted_sum = '0;
    for (int k = 0; k < adler_pkg::LANE_CNT; k++) begin
      byte_sum     = byte_sum + adler_pkg::BSUM_W'(lane_byte[k]);
      weighted_sum = weighted_sum + adler_pkg::WSUM_W'(lane_weighted[k]);
    end
    merged.byte_sum     = byte_sum;
    merged.weighted_sum = weighted_sum;
    merged.count        = count_sat;
    merged.restart      = s_tuser;
  end

  assign s_tready = !stage_valid || acc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= adler_pkg::START_RST;
      stage_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) start_value <= cfg_wr_data;
      if (s_tready) stage_valid <= s_tvalid;
    end
  end

  // hold the merged word while the accumulator stalls
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) stage <= merged;
  end

  adler_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (stage_valid),
    .in_ready    (acc_ready),
    .in_word     (stage),
    .start_value (start_value),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .checksum    (m_tdata)
  );

endmodule

// ===== hdl/adler_lane.sv =====
// One byte lane: picks its byte from the word and weights it by the bytes from it to the last, itself included.
module adler_lane (
  input  logic [31:0]                     data_word,
  input  logic [adler_pkg::COUNT_W-1:0]   count,
  input  logic [adler_pkg::COUNT_W-1:0]   lane_idx,
  output logic [7:0]                      lane_byte,
  output logic [10:0]                     lane_weighted
);

  logic       active;
  logic [7:0] raw_byte;
  logic [adler_pkg::COUNT_W-1:0] weight;

  // first byte sits at the top of the word
  assign raw_byte      = 8'(data_word >> (6'd24 - {lane_idx, 3'b000}));
  assign active        = (lane_idx < count);
  assign lane_byte     = active ? raw_byte : 8'd0;
  assign weight        = active ? (count - lane_idx) : '0;
  assign lane_weighted = 11'(weight) * 11'(raw_byte);

endmodule

// ===== hdl/adler_accum.sv =====
// Running sums: folds one merged lane word per cycle, unless out_ready stalls, into low and high, output register.
module adler_accum (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  adler_pkg::lane_sum_t  in_word,
  input  logic [31:0]           start_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           checksum
);

  logic [15:0] low, low_next;
  logic [15:0] high, high_next;
  logic [15:0] l0, h0;
  logic [16:0] lsum, lred;
  logic [adler_pkg::NL_W-1:0]   nl;
  logic [adler_pkg::HSUM_W-1:0] hsum;
  logic [16:0] fold, fred;
  logic        take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign checksum = {high, low};

  always_comb begin
    l0 = in_word.restart ? start_value[15:0]  : low;
    h0 = in_word.restart ? start_value[31:16] : high;
    lsum = {1'b0, l0} + 17'(in_word.byte_sum);
    lred = (lsum >= adler_pkg::ADLER_MOD) ? (lsum - adler_pkg::ADLER_MOD) : lsum;
    nl = '0;
    for (int j = 0; j < adler_pkg::LANE_CNT; j++) begin
      if (adler_pkg::COUNT_W'(j) < in_word.count) nl = nl + adler_pkg::NL_W'(l0);
    end
    hsum = adler_pkg::HSUM_W'(h0) + adler_pkg::HSUM_W'(nl)
         + adler_pkg::HSUM_W'(in_word.weighted_sum);
    // fold the bits from 16 up back in as 15 each, then one subtract
    fold = {1'b0, hsum[15:0]}
         + 17'(hsum[adler_pkg::HSUM_W-1:16]) * 17'(adler_pkg::FOLD_MUL);
    fred = (fold >= adler_pkg::ADLER_MOD) ? (fold - adler_pkg::ADLER_MOD) : fold;
    // no bytes: keep the sums as loaded, unreduced
    if (in_word.count == '0) begin
      low_next  = l0;
      high_next = h0;
    end else begin
      low_next  = lred[15:0];
      high_next = fred[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low       <= 16'd1;
      high      <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        low  <= low_next;
        high <= high_next;
      end
      if (in_ready) out_valid <= in_valid;
    end
  end

endmodule
